/* rtl/core/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, codes and controller/datapath interface types for the
// random sample set.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int CAPACITY  = 64;
	localparam int KEY_W     = 32;
	localparam int RND_W     = 31;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;
	localparam int ADDR_W    = $clog2(CAPACITY);
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int DIV_CNT_W = $clog2(RND_W);
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SAMPLE = 2'd2
	} op_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 3'd0,
		ST_PRESENT = 3'd1,
		ST_ABSENT  = 3'd2,
		ST_FULL    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_INS_WR,
		S_RMV_RD,
		S_RMV_WR,
		S_DIV,
		S_SMP_RD,
		S_FINISH
	} state_e_t;

	typedef struct packed {
		logic      load_req;
		logic      scan_start;
		logic      scan_step;
		logic      rd_last;
		logic      rd_sample;
		logic      wr_insert;
		logic      wr_remove;
		logic      div_start;
		logic      div_step;
		logic      load_out;
		logic      sample_sel;
		status_e_t out_status;
	} rss_cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_miss;
		logic set_full;
		logic set_empty;
		logic div_last;
		logic out_free;
	} rss_stat_t;

endpackage

/* rtl/core/rss_ctrl.sv */
// ----------------------------------------------------------------------------
// rss_ctrl
// Sequencer for insert, remove and sample: steps the datapath through the
// slot scan, the modulo reduction and the store updates.
// ----------------------------------------------------------------------------
module rss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_op,
	output logic              in_ready,
	input  rss_pkg::rss_stat_t stat,
	output rss_pkg::rss_cmd_t  cmd
);
	import rss_pkg::*;

	state_e_t  state_q, state_d;
	op_e_t     op_q, op_d;
	status_e_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
			st_q    <= ST_DONE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			st_q    <= st_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		st_d     = st_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.out_status = st_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					op_d = op_e_t'(in_op);
					st_d = ST_DONE;
					case (in_op)
						OP_INSERT, OP_REMOVE: begin
							cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end
						OP_SAMPLE: begin
							if (stat.set_empty) begin
								st_d = ST_EMPTY;
								state_d = S_FINISH;
							end else begin
								cmd.div_start = 1'b1;
								state_d = S_DIV;
							end
						end
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN: begin
				// hold the read index once a slot matches
				cmd.scan_step = !stat.scan_hit;
				if (stat.scan_hit) begin
					if (op_q == OP_INSERT) begin
						st_d = ST_PRESENT;
						state_d = S_FINISH;
					end else begin
						state_d = S_RMV_RD;
					end
				end else if (stat.scan_miss) begin
					if (op_q == OP_REMOVE) begin
						st_d = ST_ABSENT;
						state_d = S_FINISH;
					end else if (stat.set_full) begin
						st_d = ST_FULL;
						state_d = S_FINISH;
					end else begin
						state_d = S_INS_WR;
					end
				end
			end
			S_INS_WR: begin
				cmd.wr_insert = 1'b1;
				state_d = S_FINISH;
			end
			S_RMV_RD: begin
				cmd.rd_last = 1'b1;
				state_d = S_RMV_WR;
			end
			S_RMV_WR: begin
				cmd.wr_remove = 1'b1;
				state_d = S_FINISH;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_SMP_RD;
				end
			end
			S_SMP_RD: begin
				cmd.rd_sample = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.sample_sel = (op_q == OP_SAMPLE) && (st_q == ST_DONE);
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_scan_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ($past(state_q) == S_IDLE || $past(state_q) == S_SCAN))
		else $error("scan entered from wrong state");
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && in_valid) |=> (state_q != S_IDLE || $past(in_op) == 2'd3))
		else $error("transfer accepted but sequencer stayed idle");
	a_remove_after_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMV_RD) |-> (op_q == OP_REMOVE))
		else $error("store move outside a remove");

endmodule

/* rtl/core/rss_datapath.sv */
// ----------------------------------------------------------------------------
// rss_datapath
// Slot store, member count, slot scan, bit-serial modulo unit and the
// result register.
// ----------------------------------------------------------------------------
module rss_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rss_pkg::rss_cmd_t               cmd,
	output rss_pkg::rss_stat_t              stat,
	input  logic [rss_pkg::KEY_W-1:0]       in_key,
	input  logic [rss_pkg::RND_W-1:0]       in_rnd,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [rss_pkg::STATUS_W-1:0]    out_status,
	output logic [rss_pkg::KEY_W-1:0]       out_key,
	output logic [rss_pkg::COUNT_W-1:0]     out_count
);
	import rss_pkg::*;

	logic [KEY_W-1:0]     mem_q [CAPACITY];
	logic [KEY_W-1:0]     rd_data_q;
	logic [ADDR_W-1:0]    rd_idx_q;
	logic                 rdv_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     count_q;
	logic [KEY_W-1:0]     key_q;
	logic [RND_W-1:0]     rnd_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [KEY_W-1:0]     out_key_q;
	logic [COUNT_W-1:0]   out_count_q;

	logic                 scan_rd;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [KEY_W-1:0]     wr_data;
	logic [CNT_W:0]       trial;
	logic [CNT_W:0]       divisor;

	assign scan_rd = cmd.scan_step && (idx_q != count_q);
	assign rd_en   = scan_rd || cmd.rd_last || cmd.rd_sample;

	always_comb begin
		rd_addr = idx_q[ADDR_W-1:0];
		if (cmd.rd_last) begin
			rd_addr = ADDR_W'(count_q - CNT_W'(1));
		end else if (cmd.rd_sample) begin
			rd_addr = rem_q[ADDR_W-1:0];
		end
	end

	assign wr_en   = cmd.wr_insert || cmd.wr_remove;
	assign wr_addr = cmd.wr_remove ? rd_idx_q : count_q[ADDR_W-1:0];
	assign wr_data = cmd.wr_remove ? rd_data_q : key_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// restoring modulo, one quotient bit per cycle
	assign trial   = {rem_q, rnd_q[RND_W-1]};
	assign divisor = {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			key_q <= in_key;
			rnd_q <= in_rnd;
		end else if (cmd.div_step) begin
			rnd_q <= {rnd_q[RND_W-2:0], 1'b0};
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= divisor) begin
				rem_q <= CNT_W'(trial - divisor);
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
		if (scan_rd) begin
			rd_idx_q <= idx_q[ADDR_W-1:0];
		end
		if (cmd.load_out) begin
			out_status_q <= cmd.out_status;
			out_key_q    <= cmd.sample_sel ? rd_data_q : '0;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rdv_q       <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wr_remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
				rdv_q <= 1'b0;
			end else if (cmd.scan_step) begin
				rdv_q <= scan_rd;
				if (scan_rd) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.scan_hit  = rdv_q && (rd_data_q == key_q);
	assign stat.scan_miss = !rdv_q && (idx_q == count_q);
	assign stat.set_full  = (count_q == CNT_W'(CAPACITY));
	assign stat.set_empty = (count_q == '0);
	assign stat.div_last  = (div_cnt_q == DIV_CNT_W'(RND_W - 1));
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_count  = out_count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("member count beyond capacity");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_insert |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the count");
	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_sample |-> (rem_q < count_q))
		else $error("sample slot outside the valid slots");
	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

endmodule

/* rtl/core/random_sample_set.sv */
// ----------------------------------------------------------------------------
// random_sample_set
// Set of distinct signed 32-bit keys with insert, remove and random sample.
// ----------------------------------------------------------------------------
// insert and remove scan the stored slots one per cycle through the store's
// single read port
// sample reduces random_word modulo the count one bit per cycle
// one item at a time; the next item is taken once the result is registered,
// even while that result still waits on the output
// asynchronous reset empties the set at once; no clearing pass is needed
module random_sample_set (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// key[31:0], random_word[62:32], zero[63]
	input  logic [rss_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic [1:0]                       s_axis_tuser,  // operation[1:0]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// sampled_key[31:0], member_count[38:32], zero[39]
	output logic [rss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [2:0]                       m_axis_tuser   // status[2:0]
);
	import rss_pkg::*;

	rss_cmd_t            cmd;
	rss_stat_t           stat;
	logic [KEY_W-1:0]    out_key;
	logic [COUNT_W-1:0]  out_count;

	rss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rss_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_key     (s_axis_tdata[KEY_W-1:0]),
		.in_rnd     (s_axis_tdata[KEY_W+RND_W-1:KEY_W]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_key    (out_key),
		.out_count  (out_count)
	);

	assign m_axis_tdata = {1'b0, out_count, out_key};

endmodule

/* sim/random_sample_set_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// random_sample_set_tb
// Self-checking bench for the random sample set: a short table of directed
// transfers, then phases that fill the set to capacity, drain it to empty and
// mix all operations, each result checked against a table row or behavioural model.
// ----------------------------------------------------------------------------
module random_sample_set_tb;

	import rss_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1400;
	localparam int KEY_POOL_N   = 96;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 100;

	localparam int PH_FILL  = 0;
	localparam int PH_DRAIN = 1;
	localparam int PH_MIX   = 2;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [RND_W-1:0] rnd;
	} set_req_t;

	typedef struct {
		status_e_t          status;
		logic [KEY_W-1:0]   sampled;
		logic [COUNT_W-1:0] count;
	} set_resp_t;

	typedef struct {
		set_req_t  req;
		bit        typed;
		set_resp_t resp;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // key[31:0], random_word[62:32], zero[63]
	logic [1:0]  s_axis_tuser = '0;  // operation[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;       // sampled_key[31:0], member_count[38:32], zero[39]
	logic [2:0]  m_axis_tuser;       // status[2:0]

	// model of the set contents
	logic [KEY_W-1:0] held_keys[CAPACITY];
	int unsigned      held_count = 0;

	set_resp_t        pending_results[$];
	logic [KEY_W-1:0] key_pool[KEY_POOL_N];
	dir_row_t         dir_rows[$];

	bit          calm = 1'b0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned ops_seen[4];
	int unsigned status_seen[5];

	random_sample_set i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// applies one operation to the model set and returns its outcome
	function automatic set_resp_t set_op_outcome(set_req_t req);
		set_resp_t   r;
		int unsigned pos;
		bit          found;
		r.status  = ST_DONE;
		r.sampled = '0;
		found = 1'b0;
		pos = 0;
		for (int unsigned i = 0; i < held_count; i++) begin
			if (!found && held_keys[i] == req.key) begin
				found = 1'b1;
				pos = i;
			end
		end
		case (req.op)
			OP_INSERT: begin
				if (found)
					r.status = ST_PRESENT;
				else if (held_count >= CAPACITY)
					r.status = ST_FULL;
				else begin
					held_keys[held_count] = req.key;
					held_count++;
				end
			end
			OP_REMOVE: begin
				if (!found)
					r.status = ST_ABSENT;
				else begin
					held_keys[pos] = held_keys[held_count-1];
					held_count--;
				end
			end
			OP_SAMPLE: begin
				if (held_count == 0)
					r.status = ST_EMPTY;
				else
					r.sampled = held_keys[{1'b0, req.rnd} % held_count];
			end
			default: ;
		endcase
		r.count = held_count[COUNT_W-1:0];
		return r;
	endfunction

	// mostly short gaps, a few long ones, none while calm
	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [KEY_W-1:0] pick_key(int unsigned hit_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < hit_pct && held_count > 0)
			return held_keys[$urandom_range(0, held_count - 1)];
		if (r < 88)
			return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
		return $urandom();
	endfunction

	function automatic logic [OP_W-1:0] pick_op(int phase);
		int unsigned r;
		int unsigned ins_pct;
		int unsigned rmv_pct;
		r = $urandom_range(0, 99);
		case (phase)
			PH_FILL:  begin ins_pct = 80; rmv_pct = 7;  end
			PH_DRAIN: begin ins_pct = 7;  rmv_pct = 75; end
			default:  begin ins_pct = 35; rmv_pct = 35; end
		endcase
		if (r < ins_pct)
			return OP_INSERT;
		if (r < ins_pct + rmv_pct)
			return OP_REMOVE;
		if (r < 97)
			return OP_SAMPLE;
		return OP_UNUSED;
	endfunction

	function automatic dir_row_t dir_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [RND_W-1:0] rnd, bit typed, status_e_t st, logic [KEY_W-1:0] smp,
			logic [COUNT_W-1:0] cnt);
		dir_row_t d;
		d.req   = '{op, key, rnd};
		d.typed = typed;
		d.resp  = '{st, smp, cnt};
		return d;
	endfunction

	task automatic send_item(set_req_t req, bit typed, set_resp_t typed_resp);
		int unsigned gap;
		set_resp_t   predicted;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, req.rnd, req.key};
		s_axis_tuser  <= req.op;
		do @(posedge clk); while (!s_axis_tready);
		predicted = set_op_outcome(req);
		pending_results.push_back(typed ? typed_resp : predicted);
		ops_seen[req.op]++;
		status_seen[predicted.status]++;
		items_sent++;
	endtask

	task automatic await_results();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic check_result();
		set_resp_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			$error("unexpected result transfer: status %0d count %0d", m_axis_tuser,
				m_axis_tdata[38:32]);
		end else begin
			want = pending_results.pop_front();
			if (m_axis_tuser !== want.status) begin
				fail_count++;
				$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
			end
			if (m_axis_tdata[31:0] !== want.sampled) begin
				fail_count++;
				$error("sampled_key: expected %h, got %h", want.sampled, m_axis_tdata[31:0]);
			end
			if (m_axis_tdata[38:32] !== want.count) begin
				fail_count++;
				$error("member_count: expected %0d, got %0d", want.count,
					m_axis_tdata[38:32]);
			end
		end
		results_seen++;
	endtask

	// result side: check each transfer, then stall at random
	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				hold = idle_gap();
			end
		end
	end

	// ends the run if neither side moves for too long
	initial begin
		int unsigned idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int        phase_no;
		int        phase;
		int        n;
		int        tail;
		set_req_t  req;
		set_resp_t none;

		none = '{ST_DONE, '0, '0};
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < KEY_POOL_N; i++)
			key_pool[i] = (i < 24) ? i - 12 : $urandom();

		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h1234_5678, 31'h7fff_ffff, 1, ST_EMPTY,   '0, 0));
		dir_rows.push_back(dir_row(OP_REMOVE,  32'h0000_0000, 31'h0,         1, ST_ABSENT,  '0, 0));
		dir_rows.push_back(dir_row(OP_UNUSED,  32'hffff_ffff, 31'h7fff_ffff, 1, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_INSERT,  32'h8000_0000, 31'h7fff_ffff, 1, ST_DONE,    '0, 1));
		dir_rows.push_back(dir_row(OP_INSERT,  32'h7fff_ffff, 31'h0,         1, ST_DONE,    '0, 2));
		dir_rows.push_back(dir_row(OP_INSERT,  32'h8000_0000, 31'h0,         1, ST_PRESENT, '0, 2));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h0000_0000, 31'h7fff_ffff, 1, ST_DONE,
			32'h7fff_ffff, 2));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'hffff_ffff, 31'h0,         1, ST_DONE,
			32'h8000_0000, 2));
		dir_rows.push_back(dir_row(OP_INSERT,  32'h0000_0000, 31'h0,         1, ST_DONE,    '0, 3));
		dir_rows.push_back(dir_row(OP_INSERT,  32'hffff_ffff, 31'h0,         1, ST_DONE,    '0, 4));
		// freed first slot takes the last key
		dir_rows.push_back(dir_row(OP_REMOVE,  32'h8000_0000, 31'h0,         1, ST_DONE,    '0, 3));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h0000_0000, 31'h0,         0, ST_DONE,    '0, 0));
		// key sits in the last slot
		dir_rows.push_back(dir_row(OP_REMOVE,  32'h0000_0000, 31'h0,         1, ST_DONE,    '0, 2));
		dir_rows.push_back(dir_row(OP_REMOVE,  32'h0000_0000, 31'h0,         1, ST_ABSENT,  '0, 2));
		dir_rows.push_back(dir_row(OP_UNUSED,  32'h0000_0000, 31'h0,         1, ST_DONE,    '0, 2));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h5555_5555, 31'h4000_0001, 0, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_REMOVE,  32'h7fff_ffff, 31'h0,         1, ST_DONE,    '0, 1));
		dir_rows.push_back(dir_row(OP_REMOVE,  32'hffff_ffff, 31'h0,         1, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h0000_0000, 31'h2aaa_aaaa, 1, ST_EMPTY,   '0, 0));
		dir_rows.push_back(dir_row(OP_INSERT,  32'h5555_5555, 31'h2aaa_aaaa, 0, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_INSERT,  32'haaaa_aaaa, 31'h5555_5555, 0, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h0000_0000, 31'h2aaa_aaaa, 0, ST_DONE,    '0, 0));
		dir_rows.push_back(dir_row(OP_SAMPLE,  32'h0000_0000, 31'h5555_5555, 0, ST_DONE,    '0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].resp);

		// hold the sender off until the directed results are all back
		s_axis_tvalid <= 1'b0;
		await_results();

		phase_no = 0;
		while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
			phase = phase_no % 3;
			calm  = ($urandom_range(0, 3) == 0);
			n = 0;
			tail = 0;
			while (n < 300 && tail < 16 && items_sent < dir_rows.size() + RANDOM_ITEMS) begin
				req.op  = pick_op(phase);
				req.key = pick_key((phase == PH_DRAIN) ? 80 : 40);
				req.rnd = RND_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) :
					$urandom());
				send_item(req, 1'b0, none);
				n++;
				if ((phase == PH_FILL && held_count == CAPACITY) ||
						(phase == PH_DRAIN && held_count == 0) ||
						(phase == PH_MIX && n >= 120))
					tail++;
			end
			calm = 1'b0;
			if (phase_no % 2 == 1) begin
				s_axis_tvalid <= 1'b0;
				await_results();
			end
			phase_no++;
		end
		s_axis_tvalid <= 1'b0;

		await_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transfers over %0d phases: insert %0d, remove %0d, sample %0d, unused %0d",
			items_sent, phase_no, ops_seen[OP_INSERT], ops_seen[OP_REMOVE],
			ops_seen[OP_SAMPLE], ops_seen[OP_UNUSED]);
		$display("statuses done %0d, present %0d, absent %0d, full %0d, empty %0d; %0d results checked",
			status_seen[ST_DONE], status_seen[ST_PRESENT], status_seen[ST_ABSENT],
			status_seen[ST_FULL], status_seen[ST_EMPTY], results_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/core/rss_pkg.sv
rtl/core/rss_ctrl.sv
rtl/core/rss_datapath.sv
rtl/core/random_sample_set.sv
sim/random_sample_set_tb.sv
